// ===== sv/layered_keymap_report_builder_unit_assert.svh =====
// Assertion macros for the keymap report builder
`ifndef LAYERED_KEYMAP_REPORT_BUILDER_UNIT_ASSERT_SVH
`define LAYERED_KEYMAP_REPORT_BUILDER_UNIT_ASSERT_SVH

// same-cycle implication
`define LKRB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LKRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lkrb_pkg.sv =====
// Types and constants shared by the keymap report builder
`default_nettype none
package lkrb_pkg;

	typedef enum logic [1:0] {
		CMD_SCAN     = 2'd0,
		CMD_LOAD_ACT = 2'd1,
		CMD_LOAD_LAY = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_TOP_LAYER = 2'd0,
		REG_ROWS      = 2'd1,
		REG_COLS      = 2'd2,
		REG_TERM      = 2'd3
	} reg_idx_t;

	localparam logic [3:0] ACT_KEY    = 4'd0;
	localparam logic [3:0] ACT_MOD    = 4'd1;
	localparam logic [3:0] ACT_LT     = 4'd2;
	localparam logic [3:0] ACT_MT     = 4'd3;
	localparam logic [3:0] ACT_MODKEY = 4'd4;

	localparam int SLOTS = 5;
	localparam int SCAN_BITS = 64;

	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  scan_dev;
		logic [3:0]  scan_mat;
		logic [63:0] scan_bits;
		logic [3:0]  layer;
		logic [2:0]  row;
		logic [3:0]  col;
		logic [15:0] action_word;
		logic [3:0]  layout_device;
		logic [3:0]  layout_matrix;
		logic [1:0]  layout_row;
		logic [3:0]  layout_col;
	} req_t;

	typedef struct packed {
		logic [7:0] modifiers;
		logic [7:0] key_0;
		logic [7:0] key_1;
		logic [7:0] key_2;
		logic [7:0] key_3;
		logic [7:0] key_4;
		logic       last;
	} res_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_P1_RD,
		OP_P1_EV,
		OP_P1_SR,
		OP_P2_RD,
		OP_P2_ST,
		OP_P2_SR,
		OP_REP1,
		OP_REP2
	} op_t;

	typedef struct packed {
		op_t  op;
		logic key_step;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan;
		logic empty;
		logic last_key;
		logic need_search;
		logic done;
		logic tapped;
	} ctl_sts_t;

endpackage
`default_nettype wire

// ===== sv/lkrb_ctrl.sv =====
// Sequencer for the two key walks and the report output
`default_nettype none
module lkrb_ctrl
	import lkrb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire ctl_sts_t sts,
	output ctl_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_P1_RD, S_P1_EV, S_P1_SR, S_P2_RD, S_P2_ST, S_P2_SR, S_REP1, S_REP2
	} state_t;

	state_t state_q, state_n;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_n = state_q;
		cmd.op = OP_NONE;
		cmd.key_step = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_ACCEPT;
					if (sts.scan)
						state_n = sts.empty ? S_REP1 : S_P1_RD;
				end
			end
			S_P1_RD: begin
				cmd.op = OP_P1_RD;
				state_n = S_P1_EV;
			end
			S_P1_EV: begin
				cmd.op = OP_P1_EV;
				if (sts.need_search) begin
					state_n = S_P1_SR;
				end else begin
					cmd.key_step = 1'b1;
					state_n = sts.last_key ? S_P2_RD : S_P1_RD;
				end
			end
			S_P1_SR: begin
				cmd.op = OP_P1_SR;
				if (sts.done) begin
					cmd.key_step = 1'b1;
					state_n = sts.last_key ? S_P2_RD : S_P1_RD;
				end
			end
			S_P2_RD: begin
				cmd.op = OP_P2_RD;
				state_n = S_P2_ST;
			end
			S_P2_ST: begin
				cmd.op = OP_P2_ST;
				state_n = S_P2_SR;
			end
			S_P2_SR: begin
				cmd.op = OP_P2_SR;
				if (sts.done) begin
					cmd.key_step = 1'b1;
					state_n = sts.last_key ? S_REP1 : S_P2_RD;
				end
			end
			S_REP1: begin
				cmd.op = OP_REP1;
				state_n = sts.tapped ? S_REP2 : S_IDLE;
			end
			S_REP2: begin
				cmd.op = OP_REP2;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule
`default_nettype wire

// ===== sv/lkrb_dp.sv =====
// Tables, key state, layer search and report assembly
`default_nettype none
module lkrb_dp
	import lkrb_pkg::*;
#(
	parameter int LOGICAL_ROWS = 8,
	parameter int LOGICAL_COLS = 16,
	parameter int LAYER_COUNT  = 16,
	parameter int SCAN_ROWS    = 4,
	parameter int SCAN_COLS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire req_t        req,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_data,
	input  wire ctl_cmd_t    cmd,
	output ctl_sts_t         sts,
	output res_t             res,
	output logic             res_valid
);

	localparam int KEY_COUNT = LOGICAL_ROWS * LOGICAL_COLS;
	localparam int ACT_DEPTH = LAYER_COUNT * KEY_COUNT;
	localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int AW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
	localparam int LW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
	localparam int RW = $clog2(LOGICAL_ROWS + 1);
	localparam int CW = $clog2(LOGICAL_COLS + 1);

	// configuration
	logic [3:0]  top_q, rows_q;
	logic [4:0]  cols_q;
	logic [15:0] term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= 4'd0;
			rows_q <= 4'd8;
			cols_q <= 5'd16;
			term_q <= 16'd250;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TOP_LAYER: top_q <= cfg_data[3:0];
				REG_ROWS:      rows_q <= cfg_data[3:0];
				REG_COLS:      cols_q <= cfg_data[4:0];
				REG_TERM:      term_q <= cfg_data;
			endcase
		end
	end

	logic [RW-1:0] rows_eff;
	logic [CW-1:0] cols_eff;
	logic [LW-1:0] top_eff;

	assign rows_eff = (32'(rows_q) > LOGICAL_ROWS) ? RW'(LOGICAL_ROWS) : RW'(rows_q);
	assign cols_eff = (32'(cols_q) > LOGICAL_COLS) ? CW'(LOGICAL_COLS) : CW'(cols_q);
	assign top_eff = (32'(top_q) >= LAYER_COUNT) ? LW'(LAYER_COUNT - 1) : LW'(top_q);

	// scan transaction latched at accept
	logic [3:0]  dev_q, mat_q;
	logic [63:0] bits_q;

	// key walk position
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [KW-1:0] k_idx;
	logic          last_key;

	assign k_idx = KW'(32'(r_q) * LOGICAL_COLS + 32'(c_q));
	assign last_key = (c_q == CW'(cols_eff - 1'b1)) && (r_q == RW'(rows_eff - 1'b1));

	// per-layer search state
	logic [15:0]   mask_q;
	logic [LW-1:0] l_q, lsel;

	function automatic logic [LW-1:0] pick(input logic [LW-1:0] s, input logic [15:0] m);
		logic [LW-1:0] p;
		p = '0;
		for (int i = 0; i < LAYER_COUNT; i++) begin
			if (LW'(i) <= s && (i == 0 || m[i]))
				p = LW'(i);
		end
		return p;
	endfunction

	// memories
	logic [13:0] lay_mem [KEY_COUNT];
	logic [5:0]  key_mem [KEY_COUNT];
	logic [15:0] act_mem [ACT_DEPTH];
	logic [KEY_COUNT-1:0] kv_q;
	logic [13:0] lay_rd_q;
	logic [5:0]  kw_rd_q;
	logic        kv_rd_q;
	logic [15:0] act_rd_q;
	logic [AW-1:0] act_addr;
	logic [5:0]  kw;
	logic [4:0]  wnow;
	logic        was;

	assign kw = kv_rd_q ? kw_rd_q : 6'd0;
	assign wnow = kw[4:0];
	assign was = kw[5];

	// load addresses
	logic          ld_ok;
	logic [KW-1:0] ld_key;
	logic          accept_load_act, accept_load_lay;

	assign ld_ok = (32'(req.row) < LOGICAL_ROWS) && (32'(req.col) < LOGICAL_COLS);
	assign ld_key = KW'(32'(req.row) * LOGICAL_COLS + 32'(req.col));
	assign accept_load_act = (cmd.op == OP_ACCEPT) && (req.cmd == CMD_LOAD_ACT) && ld_ok
		&& (32'(req.layer) < LAYER_COUNT);
	assign accept_load_lay = (cmd.op == OP_ACCEPT) && (req.cmd == CMD_LOAD_LAY) && ld_ok;

	always_comb begin
		unique case (cmd.op)
			OP_P1_EV: lsel = pick(top_eff, mask_q);
			OP_P2_ST: lsel = pick(LW'(wnow[3:0]), mask_q);
			default:  lsel = pick(l_q - 1'b1, mask_q);
		endcase
	end

	assign act_addr = AW'(32'(lsel) * KEY_COUNT + 32'(k_idx));

	always_ff @(posedge clk) begin
		if (accept_load_act)
			act_mem[AW'(32'(req.layer) * KEY_COUNT + 32'(ld_key))] <= req.action_word;
		act_rd_q <= act_mem[act_addr];
	end

	always_ff @(posedge clk) begin
		if (accept_load_lay)
			lay_mem[ld_key] <= {req.layout_device, req.layout_matrix,
				req.layout_row, req.layout_col};
		lay_rd_q <= lay_mem[k_idx];
	end

	// phase-one evaluation of one logical key
	logic       match, pressed, need_search, key_wr;
	logic [7:0] phys_idx;
	logic [5:0] kw_wr;

	assign match = (lay_rd_q[13:10] == dev_q) && (lay_rd_q[9:6] == mat_q);
	assign phys_idx = 8'(32'(lay_rd_q[5:4]) * SCAN_COLS + 32'(lay_rd_q[3:0]));
	assign pressed = (32'(lay_rd_q[5:4]) < SCAN_ROWS) && (32'(lay_rd_q[3:0]) < SCAN_COLS)
		&& (32'(phys_idx) < SCAN_BITS) && bits_q[phys_idx[5:0]];
	assign need_search = match && pressed && (wnow == 5'd0);

	logic srch_done;
	assign srch_done = (l_q == '0) || (act_rd_q != 16'd0);

	always_comb begin
		key_wr = 1'b0;
		kw_wr = {wnow != 5'd0, wnow};
		if (cmd.op == OP_P1_EV && !need_search) begin
			key_wr = 1'b1;
			if (match && !pressed)
				kw_wr[4:0] = 5'd0;
		end else if (cmd.op == OP_P1_SR && srch_done) begin
			key_wr = 1'b1;
			kw_wr = {1'b0, 1'b1, 4'(l_q)};
		end
	end

	always_ff @(posedge clk) begin
		if (key_wr)
			key_mem[k_idx] <= kw_wr;
		kw_rd_q <= key_mem[k_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kv_q <= '0;
			kv_rd_q <= 1'b0;
		end else begin
			if (key_wr)
				kv_q[k_idx] <= 1'b1;
			kv_rd_q <= kv_q[k_idx];
		end
	end

	// phase-two effects of one key's action
	logic [7:0]       mods_q, mods_n;
	logic [4:0][7:0]  keys_q, keys_n;
	logic [2:0]       slot_q, slot_n, tslot_q, tslot_n;
	logic             tapped_q, tapped_n;
	logic [15:0]      mask_n;
	logic             trv_q, trv_n;
	logic [RW-1:0]    trr_q, trr_n;
	logic [CW-1:0]    trc_q, trc_n;
	logic [15:0]      timer_q, timer_n;
	logic [3:0]       a_type, a_arg;
	logic [7:0]       a_code;
	logic             is_dn;

	assign a_type = act_rd_q[15:12];
	assign a_arg = act_rd_q[11:8];
	assign a_code = act_rd_q[7:0];
	assign is_dn = (wnow != 5'd0);

	function automatic logic [2:0] slot_inc(input logic [2:0] s);
		return (32'(s) == SLOTS - 1) ? 3'd0 : s + 3'd1;
	endfunction

	always_comb begin
		mods_n = mods_q;
		keys_n = keys_q;
		slot_n = slot_q;
		tslot_n = tslot_q;
		tapped_n = tapped_q;
		mask_n = mask_q;
		trv_n = trv_q;
		trr_n = trr_q;
		trc_n = trc_q;
		timer_n = timer_q;
		if (is_dn) begin
			case (a_type)
				ACT_KEY: begin
					keys_n[slot_q] = a_code;
					slot_n = slot_inc(slot_q);
				end
				ACT_MOD: mods_n = mods_q | a_code;
				ACT_LT:  mask_n = mask_q | (16'd1 << a_arg);
				ACT_MT:  mods_n = mods_q | {4'd0, a_arg};
				ACT_MODKEY: begin
					mods_n = mods_q | {4'd0, a_arg};
					keys_n[slot_q] = a_code;
					slot_n = slot_inc(slot_q);
				end
				default: ;
			endcase
			if (!was) begin
				if (a_type == ACT_LT || a_type == ACT_MT) begin
					trv_n = 1'b1;
					trr_n = r_q;
					trc_n = c_q;
					timer_n = term_q;
				end else begin
					trv_n = 1'b0;
					timer_n = 16'd0;
				end
			end
		end else if (was) begin
			if (a_type == ACT_LT)
				mask_n = mask_q & ~(16'd1 << a_arg);
			else if (a_type == ACT_MT)
				mods_n = mods_q & ~{4'd0, a_arg};
			// tap: released before the term ran out
			if (trv_q && trr_q == r_q && trc_q == c_q && timer_q != 16'd0) begin
				tapped_n = 1'b1;
				tslot_n = slot_q;
				keys_n[slot_q] = a_code;
				slot_n = slot_inc(slot_q);
			end
			trv_n = 1'b0;
			timer_n = 16'd0;
		end
	end

	logic apply;
	assign apply = (cmd.op == OP_P2_SR) && srch_done && (act_rd_q != 16'd0);

	// control state of the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 16'd1;
			trv_q <= 1'b0;
			timer_q <= 16'd0;
			tapped_q <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			l_q <= '0;
		end else begin
			if (cmd.op == OP_ACCEPT && req.cmd == CMD_SCAN) begin
				tapped_q <= 1'b0;
				r_q <= '0;
				c_q <= '0;
			end else if (cmd.op == OP_ACCEPT && req.cmd == CMD_TICK) begin
				if (timer_q != 16'd0)
					timer_q <= timer_q - 16'd1;
			end
			if (cmd.key_step) begin
				if (c_q == CW'(cols_eff - 1'b1)) begin
					c_q <= '0;
					r_q <= last_key ? '0 : r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			if (cmd.op == OP_P1_EV || cmd.op == OP_P2_ST
					|| ((cmd.op == OP_P1_SR || cmd.op == OP_P2_SR) && !srch_done))
				l_q <= lsel;
			if (apply) begin
				mask_q <= mask_n;
				trv_q <= trv_n;
				timer_q <= timer_n;
				tapped_q <= tapped_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT && req.cmd == CMD_SCAN) begin
			dev_q <= req.scan_dev;
			mat_q <= req.scan_mat;
			bits_q <= req.scan_bits;
			mods_q <= 8'd0;
			keys_q <= '0;
			slot_q <= 3'd0;
		end else if (apply) begin
			mods_q <= mods_n;
			keys_q <= keys_n;
			slot_q <= slot_n;
			tslot_q <= tslot_n;
			trr_q <= trr_n;
			trc_q <= trc_n;
		end
	end

	// result register
	res_t res_q;
	logic vld_q;
	logic [4:0][7:0] keys_out;

	always_comb begin
		keys_out = keys_q;
		if (cmd.op == OP_REP2)
			keys_out[tslot_q] = 8'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_REP1 || cmd.op == OP_REP2) begin
			res_q.modifiers <= mods_q;
			res_q.key_0 <= keys_out[0];
			res_q.key_1 <= keys_out[1];
			res_q.key_2 <= keys_out[2];
			res_q.key_3 <= keys_out[3];
			res_q.key_4 <= keys_out[4];
			res_q.last <= (cmd.op == OP_REP2) || !tapped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= (cmd.op == OP_REP1) || (cmd.op == OP_REP2);
		end
	end

	assign res = res_q;
	assign res_valid = vld_q;

	assign sts.scan = (req.cmd == CMD_SCAN);
	assign sts.empty = (rows_eff == '0) || (cols_eff == '0);
	assign sts.last_key = last_key;
	assign sts.need_search = need_search;
	assign sts.done = srch_done;
	assign sts.tapped = tapped_q;

endmodule
`default_nettype wire

// ===== sv/layered_keymap_report_builder_unit.sv =====
// Top level of the layered keymap report builder
// Loads and ticks are taken without leaving the idle state. A scan walks the
// logical keys twice: first to latch layers of new presses (each key is read and
// evaluated, then the layers are searched for a new press), then to apply actions
// (each key is read, its search is started, then at least one layer is checked).
// The layer search reads the action table one layer a cycle. busy is high for
// the whole scan. Reports appear on res with res_valid for one cycle each, one or
// two per scan, and the receiver cannot stall them. No clearing pass is needed
// after reset.
`default_nettype none
`include "layered_keymap_report_builder_unit_assert.svh"
module layered_keymap_report_builder_unit
	import lkrb_pkg::*;
#(
	parameter int LOGICAL_ROWS = 8,
	parameter int LOGICAL_COLS = 16,
	parameter int LAYER_COUNT  = 16,
	parameter int SCAN_ROWS    = 4,
	parameter int SCAN_COLS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire req_t        req,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_data,
	output res_t             res,
	output logic             res_valid
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	lkrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	lkrb_dp #(
		.LOGICAL_ROWS (LOGICAL_ROWS),
		.LOGICAL_COLS (LOGICAL_COLS),
		.LAYER_COUNT  (LAYER_COUNT),
		.SCAN_ROWS    (SCAN_ROWS),
		.SCAN_COLS    (SCAN_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res),
		.res_valid (res_valid)
	);

	`LKRB_ASSERT_NEXT(a_tap_pair, res_valid && !res.last, res_valid && res.last, "tap report missing")
	`LKRB_ASSERT_NEXT(a_scan_busy, start && !busy && req.cmd == CMD_SCAN, busy, "scan not taken")
	`LKRB_ASSERT_NEXT(a_misc_quick, start && !busy && req.cmd != CMD_SCAN, !busy, "load or tick stalled")
	`LKRB_ASSERT_NOW(a_step_busy, cmd.key_step, busy, "key walk outside a scan")

endmodule
`default_nettype wire

// ===== tb/sv/layered_keymap_report_builder_unit_test.sv =====
// Self-checking testbench for the layered keymap report builder: scan, load and tick traffic
`default_nettype none
module layered_keymap_report_builder_unit_test;
	import lkrb_pkg::*;

	localparam int KEYS     = 128;
	localparam int REQ_W    = $bits(req_t);
	localparam logic [3:0] MAIN_DEV = 4'd5;
	localparam logic [3:0] MAIN_MAT = 4'd9;

	typedef enum logic [1:0] {
		PEND_ITEM,
		PEND_CFG,
		PEND_HOLD
	} pend_kind_t;

	typedef struct {
		pend_kind_t  kind;
		req_t        rq;
		reg_idx_t    idx;
		logic [15:0] data;
		int          gap;
	} pend_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [15:0] cfg_data = '0;
	res_t        res;
	logic        res_valid;

	layered_keymap_report_builder_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.res(res), .res_valid(res_valid)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// shadow of the block
	logic [3:0]  top_c;
	logic [3:0]  rows_c;
	logic [4:0]  cols_c;
	logic [15:0] term_c;
	logic [15:0] layer_mask;
	logic        tap_valid;
	int          tap_r, tap_c;
	logic [15:0] tap_left;
	logic [4:0]  key_cur [KEYS];
	logic [4:0]  key_prev [KEYS];
	logic [15:0] act_mem [16*KEYS];
	logic [13:0] lay_mem [KEYS];

	res_t  report_q [$];
	pend_t pend_q [$];
	int    fails = 0;

	function automatic logic [15:0] resolve_action(int from, int k, output int found);
		int l;
		logic [15:0] a;
		l = from > 15 ? 15 : from;
		a = '0;
		while (1) begin
			if (l != 0 && !layer_mask[l]) begin
				l--;
				continue;
			end
			a = act_mem[l*KEYS + k];
			if (l == 0 || a != 0) break;
			l--;
		end
		found = l;
		return a;
	endfunction

	task automatic keymap_predict(req_t q);
		int rows, cols, k, lay, slot, tslot;
		logic [15:0] a;
		logic [13:0] e;
		logic [3:0] typ, arg;
		logic [7:0] code, mods;
		logic [7:0] keys [SLOTS];
		logic was, is, tapped;
		int pidx;
		res_t o;
		slot = 0; tslot = 0; mods = '0; tapped = 1'b0;
		for (int j = 0; j < SLOTS; j++) keys[j] = '0;
		case (q.cmd)
			CMD_LOAD_ACT: begin
				act_mem[q.layer*KEYS + q.row*16 + q.col] = q.action_word;
				return;
			end
			CMD_LOAD_LAY: begin
				lay_mem[q.row*16 + q.col] = {q.layout_device, q.layout_matrix,
					q.layout_row, q.layout_col};
				return;
			end
			CMD_TICK: begin
				if (tap_left != 0) tap_left--;
				return;
			end
			default: ;
		endcase
		rows = rows_c > 8 ? 8 : rows_c;
		cols = cols_c > 16 ? 16 : cols_c;
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < cols; c++)
				key_prev[r*16+c] = key_cur[r*16+c];
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < cols; c++) begin
				k = r*16 + c;
				e = lay_mem[k];
				if (e[13:10] != q.scan_dev || e[9:6] != q.scan_mat) continue;
				pidx = e[5:0];
				if (q.scan_bits[pidx]) begin
					if (key_prev[k] == 0) begin
						a = resolve_action(top_c, k, lay);
						key_cur[k] = {1'b1, lay[3:0]};
					end
				end else begin
					key_cur[k] = '0;
				end
			end
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < cols; c++) begin
				k = r*16 + c;
				was = key_prev[k] != 0;
				is = key_cur[k] != 0;
				a = resolve_action(key_cur[k][3:0], k, lay);
				if (a == 0) continue;
				typ = a[15:12]; arg = a[11:8]; code = a[7:0];
				if (is) begin
					if (typ == ACT_KEY) begin
						keys[slot] = code; slot = (slot + 1) % SLOTS;
					end else if (typ == ACT_MOD) mods |= code;
					else if (typ == ACT_LT) layer_mask[arg] = 1'b1;
					else if (typ == ACT_MT) mods |= {4'b0, arg};
					else if (typ == ACT_MODKEY) begin
						mods |= {4'b0, arg};
						keys[slot] = code; slot = (slot + 1) % SLOTS;
					end
				end
				if (!was && is) begin
					if (typ == ACT_LT || typ == ACT_MT) begin
						tap_valid = 1'b1; tap_r = r; tap_c = c; tap_left = term_c;
					end else begin
						tap_valid = 1'b0; tap_left = '0;
					end
				end
				if (was && !is) begin
					if (typ == ACT_LT) layer_mask[arg] = 1'b0;
					else if (typ == ACT_MT) mods &= ~{4'b0, arg};
					if (tap_valid && tap_r == r && tap_c == c && tap_left != 0) begin
						tapped = 1'b1; tslot = slot;
						keys[slot] = code; slot = (slot + 1) % SLOTS;
					end
					tap_valid = 1'b0; tap_left = '0;
				end
			end
		o = '{mods, keys[0], keys[1], keys[2], keys[3], keys[4], !tapped};
		report_q.push_back(o);
		if (tapped) begin
			keys[tslot] = '0;
			o = '{mods, keys[0], keys[1], keys[2], keys[3], keys[4], 1'b1};
			report_q.push_back(o);
		end
	endtask

	task automatic apply_reg(reg_idx_t idx, logic [15:0] d);
		case (idx)
			REG_TOP_LAYER: top_c = d[3:0];
			REG_ROWS:      rows_c = d[3:0];
			REG_COLS:      cols_c = d[4:0];
			REG_TERM:      term_c = d;
		endcase
	endtask

	// driver
	logic  pending = 1'b0;
	int    waited = 0;
	pend_t head;
	always @(posedge clk or negedge arst_n) begin
		logic nx_we;
		nx_we = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			pending <= 1'b0;
			waited <= 0;
		end else begin
			automatic logic pend_n = pending;
			automatic int wait_n = waited;
			if (start && !busy) begin
				keymap_predict(req);
				pend_n = 1'b0;
			end
			if (!pend_n && pend_q.size() > 0) begin
				head = pend_q[0];
				if (head.kind == PEND_ITEM) begin
					if (wait_n < head.gap) wait_n++;
					else begin
						void'(pend_q.pop_front());
						req <= head.rq;
						pend_n = 1'b1;
						wait_n = 0;
					end
				end else if (report_q.size() == 0 && !busy && !(start && !busy)) begin
					// let a trailing load or tick settle before touching registers
					if (wait_n < 16) wait_n++;
					else begin
						void'(pend_q.pop_front());
						wait_n = 0;
						if (head.kind == PEND_CFG) begin
							nx_we = 1'b1;
							cfg_idx <= head.idx;
							cfg_data <= head.data;
							apply_reg(head.idx, head.data);
						end
					end
				end else begin
					wait_n = 0;
				end
			end
			start <= pend_n;
			pending <= pend_n;
			waited <= wait_n;
			cfg_we <= nx_we;
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid) begin
			if (report_q.size() == 0) begin
				$error("report with none expected");
				fails++;
			end else begin
				want = report_q.pop_front();
				if (res.modifiers !== want.modifiers) begin
					$error("modifiers exp %0h got %0h", want.modifiers, res.modifiers); fails++;
				end
				if (res.key_0 !== want.key_0) begin
					$error("key_0 exp %0h got %0h", want.key_0, res.key_0); fails++;
				end
				if (res.key_1 !== want.key_1) begin
					$error("key_1 exp %0h got %0h", want.key_1, res.key_1); fails++;
				end
				if (res.key_2 !== want.key_2) begin
					$error("key_2 exp %0h got %0h", want.key_2, res.key_2); fails++;
				end
				if (res.key_3 !== want.key_3) begin
					$error("key_3 exp %0h got %0h", want.key_3, res.key_3); fails++;
				end
				if (res.key_4 !== want.key_4) begin
					$error("key_4 exp %0h got %0h", want.key_4, res.key_4); fails++;
				end
				if (res.last !== want.last) begin
					$error("last exp %0h got %0h", want.last, res.last); fails++;
				end
			end
		end
	end

	// stimulus
	logic [13:0] lay_img [KEYS];
	logic [63:0] held = '0;
	int use_rows = 8, use_cols = 16, gap_mode = 0;

	function automatic int draw_gap();
		return gap_mode == 0 ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic req_t rand_req();
		return req_t'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
	endfunction

	function automatic void push_req(req_t q, int g);
		pend_t p;
		p.kind = PEND_ITEM; p.rq = q; p.idx = REG_TOP_LAYER; p.data = '0; p.gap = g;
		pend_q.push_back(p);
	endfunction

	function automatic void push_reg(reg_idx_t idx, logic [15:0] d);
		pend_t p;
		p.kind = PEND_CFG; p.rq = '0; p.idx = idx; p.data = d; p.gap = 0;
		pend_q.push_back(p);
		if (idx == REG_ROWS) use_rows = d[3:0] > 8 ? 8 : d[3:0];
		if (idx == REG_COLS) use_cols = d[4:0] > 16 ? 16 : d[4:0];
	endfunction

	function automatic void push_hold();
		pend_t p;
		p.kind = PEND_HOLD; p.rq = '0; p.idx = REG_TOP_LAYER; p.data = '0; p.gap = 0;
		pend_q.push_back(p);
	endfunction

	// layer-taps only reach layers 0 and 1, the only layers loaded in full
	function automatic logic [15:0] rand_action(int layer);
		logic [15:0] a;
		int pick;
		a = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (layer != 0 && pick < 50) return '0;
		if (layer == 0 && pick < 8) return '0;
		if (pick < 92) a[15:12] = 4'($urandom_range(0, 4));
		if (a[15:12] == ACT_LT) a[11:8] = {3'b000, a[8]};
		return a;
	endfunction

	function automatic void push_load_act(int layer, int r, int c, logic [15:0] a, int g);
		req_t q;
		q = rand_req();
		q.cmd = CMD_LOAD_ACT; q.layer = 4'(layer); q.row = 3'(r); q.col = 4'(c);
		q.action_word = a;
		push_req(q, g);
	endfunction

	function automatic void push_load_lay(int r, int c, int g);
		req_t q;
		q = rand_req();
		q.cmd = CMD_LOAD_LAY; q.row = 3'(r); q.col = 4'(c);
		if ($urandom_range(0, 9) != 0) begin
			q.layout_device = MAIN_DEV; q.layout_matrix = MAIN_MAT;
		end
		lay_img[r*16+c] = {q.layout_device, q.layout_matrix, q.layout_row, q.layout_col};
		push_req(q, g);
	endfunction

	function automatic void push_tick(int g);
		req_t q;
		q = rand_req();
		q.cmd = CMD_TICK;
		push_req(q, g);
	endfunction

	function automatic void push_scan(logic [63:0] bits, logic main_src, int g);
		req_t q;
		q = rand_req();
		q.cmd = CMD_SCAN; q.scan_bits = bits;
		if (main_src) begin
			q.scan_dev = MAIN_DEV; q.scan_mat = MAIN_MAT;
		end
		push_req(q, g);
	endfunction

	// mostly well-formed press/release scans on keys in use, with random scans, ticks and loads as noise
	function automatic void push_random();
		int pick, k, n;
		pick = $urandom_range(0, 99);
		if (pick < 62) begin
			n = $urandom_range(1, 3);
			for (int j = 0; j < n; j++) begin
				if (use_rows > 0 && use_cols > 0) begin
					k = $urandom_range(0, use_rows-1)*16 + $urandom_range(0, use_cols-1);
					held[lay_img[k][5:0]] = ~held[lay_img[k][5:0]];
				end else begin
					held[$urandom_range(0, 63)] ^= 1'b1;
				end
			end
			push_scan(held, 1'b1, draw_gap());
		end else if (pick < 70) begin
			held = {$urandom, $urandom} & {$urandom, $urandom};
			push_scan(held, 1'($urandom_range(0, 1)), draw_gap());
		end else if (pick < 88) begin
			push_tick(draw_gap());
		end else if (pick < 95) begin
			push_load_act($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 15),
				rand_action(1), draw_gap());
		end else begin
			push_load_lay($urandom_range(0, 7), $urandom_range(0, 15), draw_gap());
		end
	endfunction

	initial begin
		int n_items;
		logic [15:0] phases [7][4];
		top_c = 0; rows_c = 8; cols_c = 16; term_c = 250;
		layer_mask = 16'h0001; tap_valid = 1'b0; tap_r = 0; tap_c = 0; tap_left = '0;
		for (int k = 0; k < KEYS; k++) begin
			key_cur[k] = '0; key_prev[k] = '0; lay_mem[k] = '0;
		end
		for (int k = 0; k < 16*KEYS; k++) act_mem[k] = '0;
		phases = '{
			'{16'd15, 16'd2, 16'd4, 16'd3},
			'{16'd7, 16'd15, 16'd31, 16'd0},
			'{16'd15, 16'd3, 16'd5, 16'hFFFF},
			'{16'd3, 16'd1, 16'd1, 16'd2},
			'{16'd15, 16'd0, 16'd0, 16'd5},
			'{16'd9, 16'd2, 16'd6, 16'd1},
			'{16'd0, 16'd8, 16'd16, 16'd250}
		};

		// fill the layout and the layers that a search can reach before any scan
		for (int k = 0; k < KEYS; k++) push_load_lay(k / 16, k % 16, 0);
		for (int l = 0; l < 2; l++)
			for (int k = 0; k < KEYS; k++)
				push_load_act(l, k / 16, k % 16, rand_action(l), 0);

		// directed: empty and full scans, foreign source, tap then release, expiry
		push_scan('0, 1'b1, 0);
		push_scan('1, 1'b1, 3);
		push_scan('1, 1'b1, 0);
		push_scan('0, 1'b1, 0);
		push_scan('1, 1'b0, 5);
		push_scan('0, 1'b0, 0);
		push_tick(0);
		push_reg(REG_TOP_LAYER, 16'd15);
		push_reg(REG_ROWS, 16'd1);
		push_reg(REG_COLS, 16'd2);
		push_reg(REG_TERM, 16'd2);
		use_rows = 1; use_cols = 2;
		// key (0,0) as a layer-tap and (0,1) as a mod-tap on layer 0
		push_load_act(0, 0, 0, {ACT_LT, 4'd1, 8'h2A}, 0);
		push_load_act(0, 0, 1, {ACT_MT, 4'hF, 8'hE4}, 0);
		push_scan(64'(1) << lay_img[0][5:0], 1'b1, 0);
		push_scan('0, 1'b1, 0);
		push_scan(64'(1) << lay_img[1][5:0], 1'b1, 2);
		push_tick(0);
		push_tick(0);
		push_tick(0);
		push_scan('0, 1'b1, 0);
		push_scan((64'(1) << lay_img[0][5:0]) | (64'(1) << lay_img[1][5:0]), 1'b1, 0);
		push_scan('0, 1'b1, 1);
		held = '0;

		n_items = 0;
		for (int p = 0; p < 7; p++) begin
			push_reg(REG_TOP_LAYER, phases[p][0]);
			push_reg(REG_ROWS, phases[p][1]);
			push_reg(REG_COLS, phases[p][2]);
			push_reg(REG_TERM, phases[p][3]);
			gap_mode = $urandom_range(0, 2);
			for (int i = 0; i < ((p == 1 || p == 6) ? 10 : 30); i++) begin
				if (i == 10) gap_mode = (gap_mode == 0) ? 1 : 0;
				if (p == 2 && i == 20) push_hold();
				push_random();
				n_items++;
			end
		end

		while (pend_q.size() > 0 || pending) @(posedge clk);
		while (report_q.size() > 0 || busy) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0 && report_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#100000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
